[hdl/lprc_pkg.sv]
// shared types, register indexes and format codes for the layer pixel
// rotate / convert block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lprc_pkg;

    localparam int MAX_DIMENSION_DEF       = 1024;
    localparam int FALLBACK_PANEL_SIZE_DEF = 256;

    localparam int COORD_W = 10;   // pixel column, line index, screen row/column
    localparam int GEO_W   = 18;   // signed geometry from 16-bit timing fields
    localparam int CFG_IDX_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ENABLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAYER_ENABLE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_PORCH     = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_END     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_H       = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_V       = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT     = 8'd7;

    // pixel formats
    localparam logic [2:0] FMT_ARGB8888 = 3'd0;
    localparam logic [2:0] FMT_RGB888   = 3'd1;
    localparam logic [2:0] FMT_RGB565   = 3'd2;
    localparam logic [2:0] FMT_RGBA8888 = 3'd3;

    localparam logic [7:0] OPAQUE_ALPHA = 8'hff;

    typedef struct packed {
        logic        display_enable;
        logic        layer_enable;
        logic [2:0]  pixel_format;
        logic [31:0] back_porch;
        logic [31:0] active_end;
        logic [31:0] window_h;
        logic [31:0] window_v;
        logic [15:0] line_count;
    } t_cfg;

    // clipped window as seen by the final stage
    typedef struct packed {
        logic                      draw_ok;   // enabled and layer not dropped
        logic signed [GEO_W-1:0]   width;     // layer width
        logic signed [GEO_W:0]     height;    // clipped layer height
        logic [COORD_W-1:0]        row_base;  // pw - 1 - x0, wrapped
        logic [COORD_W-1:0]        y0_lo;     // y0, wrapped
    } t_geom;

endpackage

`default_nettype wire

[hdl/lprc_geom.sv]
// window geometry pipeline: panel size, layer origin, drop and clip tests
// depends on lprc_pkg; three register stages fed from the config registers
`timescale 1ns / 1ps
`default_nettype none

module lprc_geom
    import lprc_pkg::*;
#(
    parameter int MAX_DIMENSION       = MAX_DIMENSION_DEF,
    parameter int FALLBACK_PANEL_SIZE = FALLBACK_PANEL_SIZE_DEF
) (
    input  wire         i_clk,
    input  wire t_cfg   i_cfg,
    output t_geom       o_geom
);

    localparam logic signed [GEO_W-1:0] MAX_S  = GEO_W'(MAX_DIMENSION);
    localparam logic signed [GEO_W-1:0] FALL_S = GEO_W'(FALLBACK_PANEL_SIZE);
    localparam logic signed [GEO_W-1:0] ONE_S  = GEO_W'(1);

    // stage 1: raw differences
    logic signed [GEO_W-1:0] n_pw, n_ph, n_x0, n_y0, n_lw, n_lh;
    logic                    n_en;
    logic signed [GEO_W-1:0] r1_pw, r1_ph, r1_x0, r1_y0, r1_lw, r1_lh;
    logic                    r1_en;

    always_comb begin
        n_pw = $signed({2'b00, i_cfg.active_end[31:16]})
             - $signed({2'b00, i_cfg.back_porch[31:16]});
        n_ph = $signed({2'b00, i_cfg.active_end[15:0]})
             - $signed({2'b00, i_cfg.back_porch[15:0]});
        n_x0 = $signed({2'b00, i_cfg.window_h[15:0]})
             - $signed({2'b00, i_cfg.back_porch[31:16]}) - ONE_S;
        n_y0 = $signed({2'b00, i_cfg.window_v[15:0]})
             - $signed({2'b00, i_cfg.back_porch[15:0]}) - ONE_S;
        n_lw = $signed({2'b00, i_cfg.window_h[31:16]})
             - $signed({2'b00, i_cfg.window_h[15:0]}) + ONE_S;
        n_lh = $signed({2'b00, i_cfg.window_v[31:16]})
             - $signed({2'b00, i_cfg.window_v[15:0]}) + ONE_S;
        n_en = i_cfg.display_enable && i_cfg.layer_enable
            && (i_cfg.pixel_format inside {FMT_ARGB8888, FMT_RGB888,
                                           FMT_RGB565, FMT_RGBA8888});
    end

    always_ff @(posedge i_clk) begin
        r1_pw <= n_pw;
        r1_ph <= n_ph;
        r1_x0 <= n_x0;
        r1_y0 <= n_y0;
        r1_lw <= n_lw;
        r1_lh <= n_lh;
        r1_en <= n_en;
    end

    // stage 2: fallback size, right edge sum, line count clip
    logic                    n_bad, n_neg;
    logic signed [GEO_W-1:0] n_pw_s, n_ph_s, n_lh1, n_lc;
    logic signed [GEO_W:0]   n_xend;
    logic signed [GEO_W-1:0] r2_pw, r2_ph, r2_x0, r2_y0, r2_lw, r2_lh;
    logic signed [GEO_W:0]   r2_xend;
    logic                    r2_neg, r2_en;

    always_comb begin
        n_bad  = (r1_pw < ONE_S) || (r1_pw > MAX_S) || (r1_ph < ONE_S) || (r1_ph > MAX_S);
        n_pw_s = n_bad ? FALL_S : r1_pw;
        n_ph_s = n_bad ? FALL_S : r1_ph;
        n_xend = {r1_x0[GEO_W-1], r1_x0} + {r1_lw[GEO_W-1], r1_lw};
        n_neg  = r1_x0[GEO_W-1] || r1_y0[GEO_W-1] || (r1_lw < ONE_S);
        n_lc   = $signed({2'b00, i_cfg.line_count});
        n_lh1  = (r1_lh > n_lc) ? n_lc : r1_lh;
    end

    always_ff @(posedge i_clk) begin
        r2_pw   <= n_pw_s;
        r2_ph   <= n_ph_s;
        r2_x0   <= r1_x0;
        r2_y0   <= r1_y0;
        r2_lw   <= r1_lw;
        r2_lh   <= n_lh1;
        r2_xend <= n_xend;
        r2_neg  <= n_neg;
        r2_en   <= r1_en;
    end

    // stage 3: drop test, panel height clip, rotated row base
    logic                    n_drop;
    logic signed [GEO_W:0]   n_room, n_lh1x, n_lh2;
    logic signed [GEO_W-1:0] n_base;
    t_geom                   r3_geom;

    always_comb begin
        n_drop = r2_neg || (r2_xend > {r2_pw[GEO_W-1], r2_pw});
        n_room = {r2_ph[GEO_W-1], r2_ph} - {r2_y0[GEO_W-1], r2_y0};
        n_lh1x = {r2_lh[GEO_W-1], r2_lh};
        n_lh2  = (n_lh1x > n_room) ? n_room : n_lh1x;
        n_base = r2_pw - ONE_S - r2_x0;
    end

    always_ff @(posedge i_clk) begin
        r3_geom.draw_ok  <= r2_en && !n_drop;
        r3_geom.width    <= r2_lw;
        r3_geom.height   <= n_lh2;
        r3_geom.row_base <= n_base[COORD_W-1:0];
        r3_geom.y0_lo    <= r2_y0[COORD_W-1:0];
    end

    assign o_geom = r3_geom;

endmodule

`default_nettype wire

[hdl/lprc_color.sv]
// color conversion pipeline: raw framebuffer word to opaque xrgb8888
// depends on lprc_pkg; three register stages to line up with the geometry
`timescale 1ns / 1ps
`default_nettype none

module lprc_color
    import lprc_pkg::*;
(
    input  wire         i_clk,
    input  wire  [2:0]  i_format,
    input  wire  [31:0] i_raw,
    output logic [31:0] o_color
);

    logic [31:0] r_raw1, n_color, r_color2, r_color3;

    always_comb begin
        case (i_format)
            FMT_ARGB8888: n_color = {OPAQUE_ALPHA, r_raw1[23:0]};
            FMT_RGBA8888: n_color = {OPAQUE_ALPHA, r_raw1[31:8]};
            FMT_RGB888:   n_color = {OPAQUE_ALPHA, r_raw1[23:0]};
            FMT_RGB565:   n_color = {OPAQUE_ALPHA, r_raw1[15:11], 3'b000,
                                     r_raw1[10:5], 2'b00, r_raw1[4:0], 3'b000};
            default:      n_color = {OPAQUE_ALPHA, 24'h000000};
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_raw1   <= i_raw;
        r_color2 <= n_color;
        r_color3 <= r_color2;
    end

    assign o_color = r_color3;

endmodule

`default_nettype wire

[hdl/layer_pixel_rotate_convert.sv]
// top level of the layer pixel rotate / convert block: config registers,
// item pipeline and result stage; depends on lprc_pkg, lprc_geom, lprc_color
`timescale 1ns / 1ps
`default_nettype none

// usage
//   pixel words enter on i_start with column, line index and raw bytes; busy
//   stays low, so a new word is taken at every clock edge where start is high
//   throughput: one word per clock, no dependence between words
//   result: the strobe o_result_valid is high for one cycle once the word has
//   passed four register stages (input/config differences, fallback and sums,
//   drop and clip, result register)
//   the geometry path recomputes from the config registers every cycle, so
//   the critical path is one 19-bit add and compare per stage
//   each word yields exactly one result; undrawn pixels give write enable 0
//   and zero row, column and color
//   config: writes on i_cfg_valid (ready always high), index 0..7 selects a
//   register, other indexes are ignored; write only while no word is in flight
//   reset (i_rst_n low, synchronous) clears the pipeline valid bits and all
//   config registers; words in flight at reset are dropped
//   the receiver cannot stall: results are shown for exactly one cycle
module layer_pixel_rotate_convert
    import lprc_pkg::*;
#(
    parameter int MAX_DIMENSION       = MAX_DIMENSION_DEF,
    parameter int FALLBACK_PANEL_SIZE = FALLBACK_PANEL_SIZE_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // pixel word in
    input  wire                  i_start,
    output logic                 o_busy,
    input  wire  [COORD_W-1:0]   i_pixel_column,
    input  wire  [COORD_W-1:0]   i_line_index,
    input  wire  [31:0]          i_raw_pixel,
    // result word out
    output logic                 o_result_valid,
    output logic [COORD_W-1:0]   o_screen_row,
    output logic [COORD_W-1:0]   o_screen_column,
    output logic [31:0]          o_pixel_color,
    output logic                 o_write_enable,
    // config write channel
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [31:0]          i_cfg_data
);

    localparam int STAGES = 3;

    // config registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DISPLAY_ENABLE: r_cfg.display_enable <= i_cfg_data[0];
                REG_LAYER_ENABLE:   r_cfg.layer_enable   <= i_cfg_data[0];
                REG_PIXEL_FORMAT:   r_cfg.pixel_format   <= i_cfg_data[2:0];
                REG_BACK_PORCH:     r_cfg.back_porch     <= i_cfg_data;
                REG_ACTIVE_END:     r_cfg.active_end     <= i_cfg_data;
                REG_WINDOW_H:       r_cfg.window_h       <= i_cfg_data;
                REG_WINDOW_V:       r_cfg.window_v       <= i_cfg_data;
                REG_LINE_COUNT:     r_cfg.line_count     <= i_cfg_data[15:0];
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    // every cycle is a slot, so the block is never busy
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // item pipeline: valid bits and coordinates ride alongside the geometry
    logic [STAGES-1:0]  r_valid;
    logic [COORD_W-1:0] r_x [STAGES];
    logic [COORD_W-1:0] r_y [STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[STAGES-2:0], i_start && !o_busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= i_pixel_column;
        r_y[0] <= i_line_index;
        for (int s = 1; s < STAGES; s++) begin
            r_x[s] <= r_x[s-1];
            r_y[s] <= r_y[s-1];
        end
    end

    t_geom       w_geom;
    logic [31:0] w_color;

    lprc_geom #(
        .MAX_DIMENSION       (MAX_DIMENSION),
        .FALLBACK_PANEL_SIZE (FALLBACK_PANEL_SIZE)
    ) u_geom (
        .i_clk  (i_clk),
        .i_cfg  (r_cfg),
        .o_geom (w_geom)
    );

    lprc_color u_color (
        .i_clk    (i_clk),
        .i_format (r_cfg.pixel_format),
        .i_raw    (i_raw_pixel),
        .o_color  (w_color)
    );

    // result stage: per-pixel clip and rotated placement
    logic                 n_x_in, n_y_in, n_draw;
    logic                 r_out_valid, r_we;
    logic [COORD_W-1:0]   r_row, r_col;
    logic [31:0]          r_color;

    always_comb begin
        n_x_in = $signed({{(GEO_W-COORD_W){1'b0}}, r_x[STAGES-1]}) < w_geom.width;
        n_y_in = $signed({{(GEO_W+1-COORD_W){1'b0}}, r_y[STAGES-1]}) < w_geom.height;
        n_draw = w_geom.draw_ok && n_x_in && n_y_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_valid[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_we    <= n_draw;
        // rotation: screen row counts down from the panel's far edge
        r_row   <= n_draw ? (w_geom.row_base - r_x[STAGES-1]) : '0;
        r_col   <= n_draw ? (w_geom.y0_lo + r_y[STAGES-1]) : '0;
        r_color <= n_draw ? w_color : '0;
    end

    assign o_result_valid  = r_out_valid;
    assign o_write_enable  = r_we;
    assign o_screen_row    = r_row;
    assign o_screen_column = r_col;
    assign o_pixel_color   = r_color;

`ifndef SYNTH
    // every accepted word produces its result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##4 o_result_valid)
        else $error("result strobe missing after accepted word");

    // no strobe without an earlier accepted word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(i_start && !o_busy, 4))
        else $error("result strobe without accepted word");

    // a drawn pixel needs both enables set
    a_draw_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_write_enable) |->
            (r_cfg.display_enable && r_cfg.layer_enable))
        else $error("pixel drawn while display or layer disabled");

    // an undrawn pixel carries all-zero payload
    a_undrawn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_write_enable) |->
            (o_pixel_color == '0 && o_screen_row == '0 && o_screen_column == '0))
        else $error("undrawn pixel with nonzero payload");
`endif

endmodule

`default_nettype wire

[sim/testbench.sv]
// self-checking testbench for layer_pixel_rotate_convert: directed table, then random
// register settings, each followed by a burst of pixel words; depends on lprc_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
    import lprc_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RUN_LIMIT_CYCLES = 200_000;
    localparam int RANDOM_PHASES    = 22;
    localparam int WORDS_PER_PHASE  = 50;
    localparam int IDLE_PERCENT     = 27;
    localparam int DRAIN_CYCLES     = 8;     // result stage sits behind the input pipeline

    // formats the block leaves undrawn
    localparam logic [2:0] FMT_UNDRAWN_FIRST = 3'd4;
    localparam logic [2:0] FMT_UNDRAWN_LAST  = 3'd7;

    typedef struct packed {
        logic [COORD_W-1:0] screen_row;
        logic [COORD_W-1:0] screen_column;
        logic [31:0]        pixel_color;
        logic               write_enable;
    } t_pixel_result;

    // directed table rows: a register write, a word checked by the predictor,
    // or a word whose result is typed in
    typedef enum logic [1:0] {ROW_WRITE, ROW_WORD, ROW_KNOWN} t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [7:0]         reg_index;
        logic [31:0]        value;      // register data, or raw pixel bytes
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] line;
        t_pixel_result      want;
    } t_plan_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [COORD_W-1:0]   i_pixel_column;
    logic [COORD_W-1:0]   i_line_index;
    logic [31:0]          i_raw_pixel;
    logic                 o_result_valid;
    logic [COORD_W-1:0]   o_screen_row;
    logic [COORD_W-1:0]   o_screen_column;
    logic [31:0]          o_pixel_color;
    logic                 o_write_enable;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    // shadow copy of the register file, updated on every accepted write
    logic        display_on;
    logic        layer_on;
    logic [2:0]  pixel_fmt;
    logic [31:0] back_porch;
    logic [31:0] active_end;
    logic [31:0] window_h;
    logic [31:0] window_v;
    logic [15:0] line_total;

    t_pixel_result pending_pixels [$];   // predicted results, oldest first

    int  mismatch_count = 0;
    int  words_sent     = 0;
    int  drawn_words    = 0;
    int  results_seen   = 0;
    int  settings_used  = 0;
    bit  gaps_on        = 1'b1;

    layer_pixel_rotate_convert DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_pixel_column  (i_pixel_column),
        .i_line_index    (i_line_index),
        .i_raw_pixel     (i_raw_pixel),
        .o_result_valid  (o_result_valid),
        .o_screen_row    (o_screen_row),
        .o_screen_column (o_screen_column),
        .o_pixel_color   (o_pixel_color),
        .o_write_enable  (o_write_enable),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // directed table: reset state, full 1024x1024 panel with the corner pixels,
    // every format, undrawn formats, layer and display off, line count clip,
    // dropped window, fallback panel size, negative origin, height clipped away
    t_plan_row directed_plan [$] = '{
        '{ROW_KNOWN, '0, 32'hdeadbeef, 10'd3, 10'd5, '0},
        '{ROW_WRITE, REG_DISPLAY_ENABLE, 32'd1, '0, '0, '0},
        '{ROW_WRITE, REG_LAYER_ENABLE, 32'd1, '0, '0, '0},
        '{ROW_WRITE, REG_PIXEL_FORMAT, 32'(FMT_ARGB8888), '0, '0, '0},
        '{ROW_WRITE, REG_BACK_PORCH, 32'h0000_0000, '0, '0, '0},
        '{ROW_WRITE, REG_ACTIVE_END, 32'h0400_0400, '0, '0, '0},
        '{ROW_WRITE, REG_WINDOW_H, 32'h0400_0001, '0, '0, '0},
        '{ROW_WRITE, REG_WINDOW_V, 32'h0400_0001, '0, '0, '0},
        '{ROW_WRITE, REG_LINE_COUNT, 32'h0000_0400, '0, '0, '0},
        '{ROW_KNOWN, '0, 32'h1234_5678, 10'd0, 10'd0,
          '{10'd1023, 10'd0, 32'hff34_5678, 1'b1}},
        '{ROW_KNOWN, '0, 32'hffff_ffff, 10'd1023, 10'd1023,
          '{10'd0, 10'd1023, 32'hffff_ffff, 1'b1}},
        '{ROW_WORD, '0, 32'h0000_0000, 10'd512, 10'd3, '0},
        '{ROW_WORD, '0, 32'h8000_0001, 10'd7, 10'd900, '0},
        '{ROW_WRITE, REG_PIXEL_FORMAT, 32'(FMT_RGB888), '0, '0, '0},
        '{ROW_KNOWN, '0, 32'haabb_ccdd, 10'd0, 10'd0,
          '{10'd1023, 10'd0, 32'hffbb_ccdd, 1'b1}},
        '{ROW_WORD, '0, 32'h00ff_ffff, 10'd100, 10'd200, '0},
        '{ROW_WRITE, REG_PIXEL_FORMAT, 32'(FMT_RGBA8888), '0, '0, '0},
        '{ROW_KNOWN, '0, 32'haabb_ccdd, 10'd0, 10'd0,
          '{10'd1023, 10'd0, 32'hffaa_bbcc, 1'b1}},
        '{ROW_WRITE, REG_PIXEL_FORMAT, 32'(FMT_RGB565), '0, '0, '0},
        '{ROW_KNOWN, '0, 32'h0000_ffff, 10'd0, 10'd0,
          '{10'd1023, 10'd0, 32'hfff8_fcf8, 1'b1}},
        '{ROW_KNOWN, '0, 32'hffff_0000, 10'd0, 10'd0,
          '{10'd1023, 10'd0, 32'hff00_0000, 1'b1}},
        '{ROW_WORD, '0, 32'h0000_f800, 10'd5, 10'd6, '0},
        '{ROW_WORD, '0, 32'h0000_07e0, 10'd5, 10'd6, '0},
        '{ROW_WORD, '0, 32'h0000_001f, 10'd5, 10'd6, '0},
        '{ROW_WRITE, REG_PIXEL_FORMAT, 32'(FMT_UNDRAWN_FIRST), '0, '0, '0},
        '{ROW_KNOWN, '0, 32'h1234_5678, 10'd0, 10'd0, '0},
        '{ROW_WRITE, REG_PIXEL_FORMAT, 32'(FMT_UNDRAWN_LAST), '0, '0, '0},
        '{ROW_KNOWN, '0, 32'h1234_5678, 10'd0, 10'd0, '0},
        '{ROW_WRITE, REG_PIXEL_FORMAT, 32'(FMT_ARGB8888), '0, '0, '0},
        '{ROW_WRITE, REG_LAYER_ENABLE, 32'd0, '0, '0, '0},
        '{ROW_KNOWN, '0, 32'h1234_5678, 10'd0, 10'd0, '0},
        '{ROW_WRITE, REG_LAYER_ENABLE, 32'd1, '0, '0, '0},
        '{ROW_WRITE, REG_LINE_COUNT, 32'h0000_0002, '0, '0, '0},
        '{ROW_WORD, '0, 32'h5555_aaaa, 10'd0, 10'd1, '0},
        '{ROW_KNOWN, '0, 32'h5555_aaaa, 10'd0, 10'd2, '0},
        '{ROW_WRITE, REG_LINE_COUNT, 32'h0000_0400, '0, '0, '0},
        '{ROW_WRITE, REG_WINDOW_H, 32'h0401_0001, '0, '0, '0},
        '{ROW_KNOWN, '0, 32'h1111_2222, 10'd0, 10'd0, '0},
        '{ROW_WRITE, REG_ACTIVE_END, 32'h0000_0000, '0, '0, '0},
        '{ROW_WRITE, REG_WINDOW_H, 32'h0100_0001, '0, '0, '0},
        '{ROW_KNOWN, '0, 32'h0102_0304, 10'd0, 10'd0,
          '{10'd255, 10'd0, 32'hff02_0304, 1'b1}},
        '{ROW_WORD, '0, 32'hcafe_f00d, 10'd255, 10'd255, '0},
        '{ROW_WORD, '0, 32'hcafe_f00d, 10'd256, 10'd0, '0},
        '{ROW_WRITE, REG_BACK_PORCH, 32'h0001_0001, '0, '0, '0},
        '{ROW_KNOWN, '0, 32'h7777_7777, 10'd0, 10'd0, '0},
        '{ROW_WRITE, REG_BACK_PORCH, 32'h0000_0000, '0, '0, '0},
        '{ROW_WRITE, REG_WINDOW_V, 32'h0400_0200, '0, '0, '0},
        '{ROW_WORD, '0, 32'h7777_7777, 10'd0, 10'd0, '0},
        '{ROW_WRITE, REG_DISPLAY_ENABLE, 32'd0, '0, '0, '0},
        '{ROW_KNOWN, '0, 32'h7777_7777, 10'd0, 10'd0, '0}
    };

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // placement and color of one pixel under the current shadow registers
    function automatic t_pixel_result place_pixel(input logic [COORD_W-1:0] col,
                                                  input logic [COORD_W-1:0] line,
                                                  input logic [31:0] raw);
        int pw;
        int ph;
        int x0;
        int y0;
        int lw;
        int lh;
        bit draw;
        t_pixel_result r;
        r  = '0;
        // panel size; out of range on either axis means the fallback square
        pw = int'(active_end[31:16]) - int'(back_porch[31:16]);
        ph = int'(active_end[15:0]) - int'(back_porch[15:0]);
        if (pw < 1 || pw > MAX_DIMENSION_DEF || ph < 1 || ph > MAX_DIMENSION_DEF) begin
            pw = FALLBACK_PANEL_SIZE_DEF;
            ph = FALLBACK_PANEL_SIZE_DEF;
        end
        x0 = int'(window_h[15:0]) - int'(back_porch[31:16]) - 1;
        y0 = int'(window_v[15:0]) - int'(back_porch[15:0]) - 1;
        lw = int'(window_h[31:16]) - int'(window_h[15:0]) + 1;
        lh = int'(window_v[31:16]) - int'(window_v[15:0]) + 1;
        draw = display_on && layer_on && pixel_fmt <= FMT_RGBA8888;
        // a window with a negative origin, no width or one that does not fit horizontally drops the whole layer
        if (x0 < 0 || y0 < 0 || lw < 1 || x0 + lw > pw)
            draw = 1'b0;
        // height is clipped, not dropped
        if (lh > int'(line_total))
            lh = int'(line_total);
        if (lh > ph - y0)
            lh = ph - y0;
        if (int'(col) >= lw || int'(line) >= lh)
            draw = 1'b0;
        if (draw) begin
            r.screen_row    = COORD_W'(pw - 1 - (x0 + int'(col)));
            r.screen_column = COORD_W'(y0 + int'(line));
            r.write_enable  = 1'b1;
            case (pixel_fmt)
                FMT_ARGB8888: r.pixel_color = raw;
                FMT_RGBA8888: r.pixel_color = raw >> 8;
                FMT_RGB888:   r.pixel_color = {8'h00, raw[23:0]};
                default: begin
                    // rgb565, each channel shifted to the top of its byte
                    r.pixel_color = {8'h00, raw[15:11], 3'b000, raw[10:5], 2'b00,
                                     raw[4:0], 3'b000};
                end
            endcase
            r.pixel_color[31:24] = OPAQUE_ALPHA;
        end
        return r;
    endfunction

    // one register write; valid stays up into the next call so back-to-back
    // writes keep it high, the next word lowers it
    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        while (gaps_on && $urandom_range(99, 0) < IDLE_PERCENT) begin
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_DISPLAY_ENABLE: display_on = val[0];
            REG_LAYER_ENABLE:   layer_on   = val[0];
            REG_PIXEL_FORMAT:   pixel_fmt  = val[2:0];
            REG_BACK_PORCH:     back_porch = val;
            REG_ACTIVE_END:     active_end = val;
            REG_WINDOW_H:       window_h   = val;
            REG_WINDOW_V:       window_v   = val;
            REG_LINE_COUNT:     line_total = val[15:0];
            default: ;          // unknown index, ignored by the block
        endcase
    endtask

    // offer one pixel word, queue its expected result once it is taken
    task automatic send_word(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] line,
                             input logic [31:0] raw, input t_pixel_result want);
        i_cfg_valid <= 1'b0;
        while (gaps_on && $urandom_range(99, 0) < IDLE_PERCENT) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start        <= 1'b1;
        i_pixel_column <= col;
        i_line_index   <= line;
        i_raw_pixel    <= raw;
        do @(posedge i_clk); while (o_busy);
        pending_pixels.push_back(want);
        words_sent++;
        if (want.write_enable)
            drawn_words++;
    endtask

    // registers may only change with no word in flight
    task automatic wait_for_results();
        i_start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    // mostly a consistent panel and window with random placement, sometimes
    // pure noise in every register; extreme panel sizes come up often
    task automatic program_random_setting();
        logic [31:0] regs [8];
        int pw;
        int ph;
        int bph;
        int bpv;
        int x0;
        int y0;
        int lw;
        int lh;
        int hstart;
        int vstart;
        if ($urandom_range(3, 0) == 0) begin
            foreach (regs[i])
                regs[i] = $urandom;
        end else begin
            case ($urandom_range(3, 0))
                0:       pw = 1;
                1:       pw = MAX_DIMENSION_DEF;
                default: pw = $urandom_range(MAX_DIMENSION_DEF, 1);
            endcase
            case ($urandom_range(3, 0))
                0:       ph = 1;
                1:       ph = MAX_DIMENSION_DEF;
                default: ph = $urandom_range(MAX_DIMENSION_DEF, 1);
            endcase
            bph = $urandom_range(65535 - pw, 0);
            bpv = $urandom_range(65535 - ph, 0);
            x0  = $urandom_range(pw - 1, 0);
            lw  = $urandom_range(pw - x0, 1);
            // now and then one to a few columns too wide, so the layer drops
            if ($urandom_range(7, 0) == 0)
                lw += $urandom_range(4, 1);
            y0  = $urandom_range(ph - 1, 0);
            lh  = $urandom_range(1100, 1);
            hstart = x0 + bph + 1;
            vstart = y0 + bpv + 1;
            regs[REG_DISPLAY_ENABLE] = 32'($urandom_range(9, 0) != 0);
            regs[REG_LAYER_ENABLE]   = 32'($urandom_range(9, 0) != 0);
            regs[REG_PIXEL_FORMAT]   = ($urandom_range(9, 0) == 0)
                ? 32'($urandom_range(FMT_UNDRAWN_LAST, FMT_UNDRAWN_FIRST))
                : 32'($urandom_range(FMT_RGBA8888, FMT_ARGB8888));
            regs[REG_BACK_PORCH] = {16'(bph), 16'(bpv)};
            regs[REG_ACTIVE_END] = {16'(bph + pw), 16'(bpv + ph)};
            regs[REG_WINDOW_H]   = {16'(hstart + lw - 1), 16'(hstart)};
            regs[REG_WINDOW_V]   = {16'(vstart + lh - 1), 16'(vstart)};
            regs[REG_LINE_COUNT] = ($urandom_range(3, 0) == 0)
                ? $urandom : 32'($urandom_range(1100, 0));
        end
        for (int i = REG_DISPLAY_ENABLE; i <= REG_LINE_COUNT; i++)
            write_reg(8'(i), regs[i]);
        // a stray index above the register file must change nothing
        if ($urandom_range(3, 0) == 0)
            write_reg(REG_LINE_COUNT + 8'($urandom_range(248, 1)), $urandom);
        settings_used++;
    endtask

    // results cannot be held off: every strobe is compared on the spot
    always @(posedge i_clk) begin : result_check
        t_pixel_result want;
        if (i_rst_n && o_result_valid) begin
            results_seen++;
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("result with no word pending: row %0d col %0d",
                                          o_screen_row, o_screen_column));
            end else begin
                want = pending_pixels.pop_front();
                if (o_screen_row !== want.screen_row)
                    report_mismatch($sformatf("screen_row %0d, expected %0d",
                                              o_screen_row, want.screen_row));
                if (o_screen_column !== want.screen_column)
                    report_mismatch($sformatf("screen_column %0d, expected %0d",
                                              o_screen_column, want.screen_column));
                if (o_pixel_color !== want.pixel_color)
                    report_mismatch($sformatf("pixel_color %08h, expected %08h",
                                              o_pixel_color, want.pixel_color));
                if (o_write_enable !== want.write_enable)
                    report_mismatch($sformatf("write_enable %0b, expected %0b",
                                              o_write_enable, want.write_enable));
            end
        end
    end

    initial begin : stimulus
        t_pixel_result      want;
        int                 lw_span;
        int                 lh_span;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] line;

        // every input known from time zero, shadow registers at reset values
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_pixel_column = '0;
        i_line_index   = '0;
        i_raw_pixel    = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        display_on     = 1'b0;
        layer_on       = 1'b0;
        pixel_fmt      = '0;
        back_porch     = '0;
        active_end     = '0;
        window_h       = '0;
        window_v       = '0;
        line_total     = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_WRITE) begin
                wait_for_results();
                write_reg(directed_plan[i].reg_index, directed_plan[i].value);
            end else begin
                want = (directed_plan[i].kind == ROW_KNOWN) ? directed_plan[i].want
                     : place_pixel(directed_plan[i].col, directed_plan[i].line,
                                   directed_plan[i].value);
                send_word(directed_plan[i].col, directed_plan[i].line,
                          directed_plan[i].value, want);
            end
        end

        // random settings, each with a burst of words
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            // a stretch of several phases with both sides running flat out
            gaps_on = !(phase >= 6 && phase < 10);
            wait_for_results();
            program_random_setting();
            // window extent, used to aim most words inside the window or just past its edges
            lw_span = int'(window_h[31:16]) - int'(window_h[15:0]) + 1;
            lh_span = int'(window_v[31:16]) - int'(window_v[15:0]) + 1;
            lw_span = (lw_span < 1) ? 1 : (lw_span > 1022) ? 1022 : lw_span;
            lh_span = (lh_span < 1) ? 1 : (lh_span > 1022) ? 1022 : lh_span;
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if ($urandom_range(3, 0) == 0) begin
                    col  = COORD_W'($urandom);
                    line = COORD_W'($urandom);
                end else begin
                    col  = COORD_W'($urandom_range(lw_span + 1, 0));
                    line = COORD_W'($urandom_range(lh_span + 1, 0));
                end
                // raw bytes drawn once so the word and its prediction agree
                begin : one_word
                    logic [31:0] raw;
                    raw  = $urandom;
                    want = place_pixel(col, line, raw);
                    send_word(col, line, raw, want);
                end
            end
        end

        gaps_on = 1'b1;
        wait_for_results();
        i_cfg_valid <= 1'b0;
        // room for any stray late result to show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d pixel words (%0d drawn) over %0d random register settings",
                 words_sent, drawn_words, settings_used);
        $display("%0d results compared, %0d mismatches", results_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hard stop if a handshake never completes
    initial begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
hdl/lprc_pkg.sv
hdl/lprc_geom.sv
hdl/lprc_color.sv
hdl/layer_pixel_rotate_convert.sv
sim/testbench.sv
